@@ sv/triangular_inverse_cdf_sampler_macros.svh @@
// assertion macros for the triangular inverse cdf sampler checker
`ifndef TRIANGULAR_INVERSE_CDF_SAMPLER_MACROS_SVH
`define TRIANGULAR_INVERSE_CDF_SAMPLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TICS_ASSERT_HOLDS(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("tics checker: property violated");

// next-cycle implication, disabled during reset
`define TICS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("tics checker: property violated");

`endif

@@ sv/tics_pkg.sv @@
// shared types and constants of the triangular inverse cdf sampler
`timescale 1ns / 1ps
`default_nettype none

package tics_pkg;

    localparam int U_W        = 32;
    localparam int Q_W        = 32;
    localparam int SCALE_W    = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SUM_W      = Q_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_POINT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_HIGH  = 3'd4;

    localparam logic signed [Q_W-1:0] RST_LOWER_LIMIT = 32'sd0;
    localparam logic signed [Q_W-1:0] RST_UPPER_LIMIT = 32'sd131072;
    localparam logic [U_W-1:0]        RST_SPLIT_POINT = 32'h8000_0000;
    localparam logic [SCALE_W-1:0]    RST_SCALE_LOW   = 64'h0000_0002_0000_0000;
    localparam logic [SCALE_W-1:0]    RST_SCALE_HIGH  = 64'h0000_0002_0000_0000;

    localparam logic signed [Q_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q16_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [Q_W-1:0] lower_limit;
        logic signed [Q_W-1:0] upper_limit;
        logic [U_W-1:0]        split_point;
        logic [SCALE_W-1:0]    scale_low;
        logic [SCALE_W-1:0]    scale_high;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic                  low_branch;
        logic signed [Q_W-1:0] limit;
    } t_ctl;

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [REM_W-1:0]   rem;
        logic [SCALE_W-1:0] radicand;
    } t_sqrt;

endpackage

`default_nettype wire

@@ sv/tics_ifs.sv @@
// handshake channel interfaces of the triangular inverse cdf sampler
`timescale 1ns / 1ps
`default_nettype none

interface tics_in_if import tics_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [U_W-1:0] uniform_sample;

    modport source (output valid, output uniform_sample, input ready);
    modport sink (input valid, input uniform_sample, output ready);
endinterface

interface tics_out_if import tics_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] sample;
    logic                  saturated;

    modport source (output valid, output sample, output saturated, input ready);
    modport sink (input valid, input sample, input saturated, output ready);
endinterface

interface tics_cfg_if import tics_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/triangular_inverse_cdf_sampler.sv @@
// Triangular sampler by inverse transform: each uniform_sample (Q0.32) gives one sample
// (signed Q16.16) with a saturated flag. One item is taken per cycle unless the result side
// stalls; each result passes through 1 select stage, 1 multiply stage, 1 product add,
// 16 square root stages (two root bits each) and the output register. A stall on the
// result side holds the whole pipeline. Configuration writes are taken at any cycle and
// apply to items accepted afterwards; write them only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module triangular_inverse_cdf_sampler import tics_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    tics_in_if.sink       i_uniform,
    tics_out_if.source    o_result,
    tics_cfg_if.sink      i_cfg
);

    t_cfg               w_cfg;
    logic               w_en;
    t_ctl               w_mul_ctl;
    logic [SCALE_W-1:0] w_prod;
    t_ctl               w_sqrt_ctl;
    logic [ROOT_W-1:0]  w_root;

    logic signed [SUM_W-1:0] w_limit_ext;
    logic signed [SUM_W-1:0] w_root_ext;
    logic signed [SUM_W-1:0] w_sum;

    logic                  r_out_valid;
    logic signed [Q_W-1:0] r_out_sample;
    logic                  r_out_sat;
    logic signed [Q_W-1:0] n_out_sample;
    logic                  n_out_sat;

    assign w_en            = !r_out_valid || o_result.ready;
    assign i_uniform.ready = w_en;

    tics_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    tics_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_uniform.valid),
        .i_u     (i_uniform.uniform_sample),
        .i_cfg   (w_cfg),
        .o_ctl   (w_mul_ctl),
        .o_prod  (w_prod)
    );

    tics_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_ctl      (w_mul_ctl),
        .i_radicand (w_prod),
        .o_ctl      (w_sqrt_ctl),
        .o_root     (w_root)
    );

    assign w_limit_ext = {{(SUM_W-Q_W){w_sqrt_ctl.limit[Q_W-1]}}, w_sqrt_ctl.limit};
    assign w_root_ext  = {{(SUM_W-ROOT_W){1'b0}}, w_root};
    assign w_sum       = w_sqrt_ctl.low_branch ? w_limit_ext + w_root_ext
                                               : w_limit_ext - w_root_ext;

    always_comb begin
        if (w_sum > $signed({{(SUM_W-Q_W){1'b0}}, Q16_MAX})) begin
            n_out_sample = Q16_MAX;
            n_out_sat    = 1'b1;
        end else if (w_sum < $signed({{(SUM_W-Q_W){1'b1}}, Q16_MIN})) begin
            n_out_sample = Q16_MIN;
            n_out_sat    = 1'b1;
        end else begin
            n_out_sample = w_sum[Q_W-1:0];
            n_out_sat    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_sqrt_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_sample <= n_out_sample;
            r_out_sat    <= n_out_sat;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.sample    = r_out_sample;
    assign o_result.saturated = r_out_sat;

endmodule

`default_nettype wire

@@ sv/tics_cfg_regs.sv @@
// configuration register file
`timescale 1ns / 1ps
`default_nettype none

module tics_cfg_regs import tics_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tics_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LOWER_LIMIT: n_cfg.lower_limit = i_cfg.data[Q_W-1:0];
                REG_UPPER_LIMIT: n_cfg.upper_limit = i_cfg.data[Q_W-1:0];
                REG_SPLIT_POINT: n_cfg.split_point = i_cfg.data[U_W-1:0];
                REG_SCALE_LOW:   n_cfg.scale_low   = i_cfg.data[SCALE_W-1:0];
                REG_SCALE_HIGH:  n_cfg.scale_high  = i_cfg.data[SCALE_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_limit <= RST_LOWER_LIMIT;
            r_cfg.upper_limit <= RST_UPPER_LIMIT;
            r_cfg.split_point <= RST_SPLIT_POINT;
            r_cfg.scale_low   <= RST_SCALE_LOW;
            r_cfg.scale_high  <= RST_SCALE_HIGH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/tics_mul.sv @@
// branch select and q32.32 product, three register stages
`timescale 1ns / 1ps
`default_nettype none

module tics_mul import tics_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire [U_W-1:0]       i_u,
    input  t_cfg                i_cfg,
    output t_ctl                o_ctl,
    output logic [SCALE_W-1:0]  o_prod
);

    // stage 0: branch and operands
    t_ctl               r_s0_ctl;
    logic [U_W-1:0]     r_s0_mult;
    logic [SCALE_W-1:0] r_s0_scale;
    logic               r_s0_whole;
    t_ctl               n_s0_ctl;
    logic [U_W-1:0]     n_s0_mult;
    logic [SCALE_W-1:0] n_s0_scale;
    logic               n_s0_whole;

    // stage 1: partial products
    t_ctl               r_s1_ctl;
    logic [SCALE_W-1:0] r_s1_lo;
    logic [SCALE_W-1:0] r_s1_hi;
    logic [SCALE_W-1:0] r_s1_scale;
    logic               r_s1_whole;

    // stage 2: product
    t_ctl               r_s2_ctl;
    logic [SCALE_W-1:0] r_s2_prod;
    logic [SCALE_W-1:0] n_s2_prod;

    always_comb begin
        n_s0_ctl.valid      = i_valid;
        n_s0_ctl.low_branch = (i_u < i_cfg.split_point);
        if (n_s0_ctl.low_branch) begin
            n_s0_ctl.limit = i_cfg.lower_limit;
            n_s0_mult      = i_u;
            n_s0_scale     = i_cfg.scale_low;
            n_s0_whole     = 1'b0;
        end else begin
            n_s0_ctl.limit = i_cfg.upper_limit;
            n_s0_mult      = {U_W{1'b0}} - i_u;
            n_s0_scale     = i_cfg.scale_high;
            // one minus zero is exactly one
            n_s0_whole     = (i_u == {U_W{1'b0}});
        end
    end

    assign n_s2_prod = r_s1_whole ? r_s1_scale
                                  : r_s1_hi + {{(SCALE_W-U_W){1'b0}}, r_s1_lo[SCALE_W-1:U_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl.valid <= 1'b0;
            r_s1_ctl.valid <= 1'b0;
            r_s2_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_s0_ctl.valid <= n_s0_ctl.valid;
            r_s1_ctl.valid <= r_s0_ctl.valid;
            r_s2_ctl.valid <= r_s1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_ctl.low_branch <= n_s0_ctl.low_branch;
            r_s0_ctl.limit      <= n_s0_ctl.limit;
            r_s0_mult           <= n_s0_mult;
            r_s0_scale          <= n_s0_scale;
            r_s0_whole          <= n_s0_whole;

            r_s1_ctl.low_branch <= r_s0_ctl.low_branch;
            r_s1_ctl.limit      <= r_s0_ctl.limit;
            r_s1_lo             <= {{(SCALE_W-U_W){1'b0}}, r_s0_mult}
                                   * {{(SCALE_W-U_W){1'b0}}, r_s0_scale[U_W-1:0]};
            r_s1_hi             <= {{(SCALE_W-U_W){1'b0}}, r_s0_mult}
                                   * {{(SCALE_W-U_W){1'b0}}, r_s0_scale[SCALE_W-1:U_W]};
            r_s1_scale          <= r_s0_scale;
            r_s1_whole          <= r_s0_whole;

            r_s2_ctl.low_branch <= r_s1_ctl.low_branch;
            r_s2_ctl.limit      <= r_s1_ctl.limit;
            r_s2_prod           <= n_s2_prod;
        end
    end

    assign o_ctl  = r_s2_ctl;
    assign o_prod = r_s2_prod;

endmodule

`default_nettype wire

@@ sv/tics_sqrt.sv @@
// pipelined integer square root, two result bits per stage
`timescale 1ns / 1ps
`default_nettype none

module tics_sqrt import tics_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  t_ctl                i_ctl,
    input  wire [SCALE_W-1:0]   i_radicand,
    output t_ctl                o_ctl,
    output logic [ROOT_W-1:0]   o_root
);

    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt            v;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh     = {s.rem[REM_W-3:0], s.radicand[SCALE_W-1 -: 2]};
        trial      = {s.root, 2'b01};
        v.radicand = {s.radicand[SCALE_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            v.rem  = rem_sh - trial;
            v.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            v.rem  = rem_sh;
            v.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return v;
    endfunction

    t_ctl  r_ctl [SQRT_STAGES];
    t_sqrt r_st  [SQRT_STAGES];
    t_sqrt n_st  [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        t_sqrt w_in;
        t_ctl  w_ctl;

        if (g == 0) begin : g_first
            assign w_in.root     = {ROOT_W{1'b0}};
            assign w_in.rem      = {REM_W{1'b0}};
            assign w_in.radicand = i_radicand;
            assign w_ctl         = i_ctl;
        end else begin : g_next
            assign w_in  = r_st[g-1];
            assign w_ctl = r_ctl[g-1];
        end

        always_comb begin
            n_st[g] = w_in;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                n_st[g] = sqrt_step(n_st[g]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g].valid <= 1'b0;
            end else if (i_en) begin
                r_ctl[g].valid <= w_ctl.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[g].low_branch <= w_ctl.low_branch;
                r_ctl[g].limit      <= w_ctl.limit;
                r_st[g]             <= n_st[g];
            end
        end
    end

    assign o_ctl  = r_ctl[SQRT_STAGES-1];
    assign o_root = r_st[SQRT_STAGES-1].root;

endmodule

`default_nettype wire

@@ sv/tics_checker.sv @@
// port-level checks of the triangular inverse cdf sampler
`timescale 1ns / 1ps
`default_nettype none

`include "triangular_inverse_cdf_sampler_macros.svh"

module tics_checker import tics_pkg::*; (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_ready,
    input wire                  i_out_valid,
    input wire                  i_out_ready,
    input wire signed [Q_W-1:0] i_out_sample,
    input wire                  i_out_saturated
);

    // a held result blocks new items
    `TICS_ASSERT_HOLDS(a_stall_blocks_input, i_clk, i_rst_n,
        i_out_valid && !i_out_ready, !i_in_ready)

    // clipped results sit at a range end
    `TICS_ASSERT_HOLDS(a_sat_at_bound, i_clk, i_rst_n,
        i_out_valid && i_out_saturated,
        i_out_sample == Q16_MAX || i_out_sample == Q16_MIN)

    `TICS_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n,
        i_out_valid && !i_out_ready, i_out_valid)

    `TICS_ASSERT_NEXT(a_payload_holds, i_clk, i_rst_n,
        i_out_valid && !i_out_ready,
        $stable(i_out_sample) && $stable(i_out_saturated))

endmodule

bind triangular_inverse_cdf_sampler tics_checker u_tics_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_uniform.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_out_sample    (o_result.sample),
    .i_out_saturated (o_result.saturated)
);

`default_nettype wire
